[hdl/lppd_pkg.sv]
// Package for the length-prefixed packet deframer.
// Section codes, field widths and the result record shared by all modules.
// No dependencies.
`default_nettype none

package lppd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned STAMP_W  = 64;
  localparam int unsigned SIGLEN_W = 8;
  localparam int unsigned CNT_W    = 16;

  localparam int unsigned ADDRESS_BYTES_DEF = 6;
  localparam int unsigned STAMP_BYTES       = 8;

  // Section codes, also the byte_kind values
  localparam logic [KIND_W-1:0] SEC_LENGTH  = 3'd0;
  localparam logic [KIND_W-1:0] SEC_ADDRESS = 3'd1;
  localparam logic [KIND_W-1:0] SEC_PAYLOAD = 3'd2;
  localparam logic [KIND_W-1:0] SEC_STAMP   = 3'd3;
  localparam logic [KIND_W-1:0] SEC_SIGLEN  = 3'd4;
  localparam logic [KIND_W-1:0] SEC_SIG     = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0]   byte_kind;
    logic [BYTE_W-1:0]   byte_echo;
    logic                last;
    logic [LEN_W-1:0]    payload_length;
    logic [ADDR_W-1:0]   source_address;
    logic [ADDR_W-1:0]   destination_address;
    logic [STAMP_W-1:0]  time_stamp;
    logic [SIGLEN_W-1:0] signature_length;
  } lppd_res_t;

endpackage

`default_nettype wire

[hdl/lppd_parser.sv]
// Frame parser: section tracker, byte counter and header capture registers.
// Produces the result record for the byte presented on step. Uses lppd_pkg.
`default_nettype none

module lppd_parser
  import lppd_pkg::*;
#(
  parameter int unsigned ADDRESS_BYTES = ADDRESS_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [BYTE_W-1:0] byte_value,
  output lppd_res_t              res
);

  localparam logic [CNT_W-1:0] ADDR_HALF  = CNT_W'(ADDRESS_BYTES);
  localparam logic [CNT_W-1:0] ADDR_LIMIT = CNT_W'(2 * ADDRESS_BYTES);
  localparam logic [CNT_W-1:0] STAMP_LIM  = CNT_W'(STAMP_BYTES);

  logic [KIND_W-1:0]   section_r, section_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [SIGLEN_W-1:0] siglen_r, siglen_nxt;
  logic [ADDR_W-1:0]   src_r, src_nxt;
  logic [ADDR_W-1:0]   dst_r, dst_nxt;
  logic [STAMP_W-1:0]  stamp_r, stamp_nxt;

  logic [KIND_W-1:0] sec_eff;
  logic [CNT_W-1:0]  cnt_eff;
  logic [CNT_W-1:0]  cnt_inc;
  logic              last;

  always_comb begin
    // unused codes restart as a fresh length section
    sec_eff     = (section_r > SEC_SIG) ? SEC_LENGTH : section_r;
    cnt_eff     = (section_r > SEC_SIG) ? '0 : count_r;
    cnt_inc     = cnt_eff + CNT_W'(1);
    section_nxt = sec_eff;
    count_nxt   = cnt_eff;
    len_nxt     = len_r;
    siglen_nxt  = siglen_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    stamp_nxt   = stamp_r;
    last        = 1'b0;

    case (sec_eff)
      SEC_LENGTH: begin
        if (cnt_eff == '0) begin
          len_nxt    = {byte_value, 8'h00};
          src_nxt    = '0;
          dst_nxt    = '0;
          stamp_nxt  = '0;
          siglen_nxt = '0;
          count_nxt  = CNT_W'(1);
        end else begin
          len_nxt     = {len_r[LEN_W-1:8], byte_value};
          section_nxt = SEC_ADDRESS;
          count_nxt   = '0;
        end
      end
      SEC_ADDRESS: begin
        if (cnt_eff < ADDR_HALF) begin
          src_nxt = {src_r[ADDR_W-BYTE_W-1:0], byte_value};
        end else begin
          dst_nxt = {dst_r[ADDR_W-BYTE_W-1:0], byte_value};
        end
        count_nxt = cnt_inc;
        if (cnt_inc >= ADDR_LIMIT) begin
          // skip an empty payload
          section_nxt = (len_r == '0) ? SEC_STAMP : SEC_PAYLOAD;
          count_nxt   = '0;
        end
      end
      SEC_PAYLOAD: begin
        count_nxt = cnt_inc;
        if (cnt_inc >= len_r) begin
          section_nxt = SEC_STAMP;
          count_nxt   = '0;
        end
      end
      SEC_STAMP: begin
        stamp_nxt = {stamp_r[STAMP_W-BYTE_W-1:0], byte_value};
        count_nxt = cnt_inc;
        if (cnt_inc >= STAMP_LIM) begin
          section_nxt = SEC_SIGLEN;
          count_nxt   = '0;
        end
      end
      SEC_SIGLEN: begin
        siglen_nxt = byte_value;
        count_nxt  = '0;
        if (byte_value == '0) begin
          last        = 1'b1;
          section_nxt = SEC_LENGTH;
        end else begin
          section_nxt = SEC_SIG;
        end
      end
      SEC_SIG: begin
        count_nxt = cnt_inc;
        if (cnt_inc >= CNT_W'(siglen_r)) begin
          last        = 1'b1;
          section_nxt = SEC_LENGTH;
          count_nxt   = '0;
        end
      end
      default: begin
        section_nxt = SEC_LENGTH;
        count_nxt   = '0;
      end
    endcase

    res.byte_kind           = sec_eff;
    res.byte_echo           = byte_value;
    res.last                = last;
    res.payload_length      = last ? len_nxt    : '0;
    res.source_address      = last ? src_nxt    : '0;
    res.destination_address = last ? dst_nxt    : '0;
    res.time_stamp          = last ? stamp_nxt  : '0;
    res.signature_length    = last ? siglen_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_r <= SEC_LENGTH;
      count_r   <= '0;
      len_r     <= '0;
      siglen_r  <= '0;
      src_r     <= '0;
      dst_r     <= '0;
      stamp_r   <= '0;
    end else if (step) begin
      section_r <= section_nxt;
      count_r   <= count_nxt;
      len_r     <= len_nxt;
      siglen_r  <= siglen_nxt;
      src_r     <= src_nxt;
      dst_r     <= dst_nxt;
      stamp_r   <= stamp_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/lppd_out_stage.sv]
// Result register of the deframer: holds one result transaction until taken.
// Uses lppd_pkg for the result record.
`default_nettype none

module lppd_out_stage
  import lppd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire lppd_res_t res_in,
  input  wire logic      out_ready,
  output logic           out_valid,
  output logic           free,
  output lppd_res_t      res_out
);

  logic      valid_r;
  lppd_res_t data_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_in;
    end
  end

endmodule

`default_nettype wire

[hdl/length_prefixed_packet_deframer.sv]
// Length-prefixed packet deframer, top level.
// Input: one stream byte per transaction on in_valid/in_ready/in_byte_value.
// Output: one result per input byte on out_valid/out_ready and the out_ fields:
//   section tag, the echoed byte, last on the frame's final byte, and on that
//   byte the captured payload length, addresses, timestamp and signature length
//   (all zero on other bytes).
// Frame: 2-byte length, ADDRESS_BYTES source and destination bytes, payload,
//   8-byte timestamp, 1-byte signature length, signature. Empty payload and
//   empty signature sections are skipped.
// Path: the input register takes the byte at acceptance, and the result register
//   takes its result from the parser after that, unless the output is stalled.
//   Throughput: one byte per cycle while out_ready is high; the parser updates its
//   section and counter once for each byte taken.
// Reset: rst_n low empties both registers and puts the parser at the start of
//   a frame with all capture registers cleared.
// Stall: while out_ready is low the result register holds; one more byte may
//   sit in the input register, after which in_ready drops.
`default_nettype none

module length_prefixed_packet_deframer
  import lppd_pkg::*;
#(
  parameter int unsigned ADDRESS_BYTES = ADDRESS_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [BYTE_W-1:0]   in_byte_value,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [KIND_W-1:0]        out_byte_kind,
  output logic [BYTE_W-1:0]        out_byte_echo,
  output logic                     out_last,
  output logic [LEN_W-1:0]         out_payload_length,
  output logic [ADDR_W-1:0]        out_source_address,
  output logic [ADDR_W-1:0]        out_destination_address,
  output logic [STAMP_W-1:0]       out_time_stamp,
  output logic [SIGLEN_W-1:0]      out_signature_length
);

  logic              in_v_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_free;
  logic              adv;
  lppd_res_t         parse_res;
  lppd_res_t         out_res;

  // advance the held byte when the result register can take it
  assign adv      = in_v_r && out_free;
  assign in_ready = !in_v_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte_value;
    end
  end

  lppd_parser #(
    .ADDRESS_BYTES(ADDRESS_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .byte_value(in_byte_r),
    .res       (parse_res)
  );

  lppd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (adv),
    .res_in   (parse_res),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .free     (out_free),
    .res_out  (out_res)
  );

  assign out_byte_kind           = out_res.byte_kind;
  assign out_byte_echo           = out_res.byte_echo;
  assign out_last                = out_res.last;
  assign out_payload_length      = out_res.payload_length;
  assign out_source_address      = out_res.source_address;
  assign out_destination_address = out_res.destination_address;
  assign out_time_stamp          = out_res.time_stamp;
  assign out_signature_length    = out_res.signature_length;

`ifndef SYNTHESIS
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (out_byte_kind == SEC_SIGLEN || out_byte_kind == SEC_SIG))
    else $error("last on a byte outside the signature sections");

  a_zero_unless_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> (out_payload_length == '0 && out_source_address == '0 &&
      out_destination_address == '0 && out_time_stamp == '0 &&
      out_signature_length == '0))
    else $error("captured fields nonzero on a non-final byte");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte_kind <= SEC_SIG)
    else $error("section tag out of range");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while both stages are full and stalled");
`endif

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Testbench for length_prefixed_packet_deframer: drives a byte stream of whole frames
// and checks every tagged byte against a behavioral parser kept in this file.
// Depends on lppd_pkg and the deframer RTL only.

module tb_top;
  import lppd_pkg::*;

  localparam int CAPT_W          = LEN_W + 2 * ADDR_W + STAMP_W + SIGLEN_W;
  localparam int N_DIRECTED      = 23;
  localparam int RANDOM_BYTES    = 700;
  localparam int PRESSURE_AT     = 400;
  localparam int PRESSURE_CYCLES = 250;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 10;

  localparam logic [CAPT_W-1:0] NO_CAPTURE = '0;
  localparam lppd_res_t         NO_RESULT  = '0;

  typedef struct packed {
    logic [BYTE_W-1:0] stim;
    logic              typed;
    lppd_res_t         res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_byte_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [KIND_W-1:0]   out_byte_kind;
  logic [BYTE_W-1:0]   out_byte_echo;
  logic                out_last;
  logic [LEN_W-1:0]    out_payload_length;
  logic [ADDR_W-1:0]   out_source_address;
  logic [ADDR_W-1:0]   out_destination_address;
  logic [STAMP_W-1:0]  out_time_stamp;
  logic [SIGLEN_W-1:0] out_signature_length;

  // Parser state mirrored on the testbench side
  logic [KIND_W-1:0]   p_section;
  logic [CNT_W-1:0]    p_count;
  logic [LEN_W-1:0]    p_length;
  logic [SIGLEN_W-1:0] p_siglen;
  logic [ADDR_W-1:0]   p_source;
  logic [ADDR_W-1:0]   p_dest;
  logic [STAMP_W-1:0]  p_stamp;

  lppd_res_t deframed_due[$];
  int        bytes_sent = 0;
  int        bytes_checked = 0;
  int        frames_seen = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        gap_pct = 0;
  bit        calm = 1'b0;

  // Empty payload and empty signature frame; extremes in length, source and timestamp
  dir_row_t directed_rows [N_DIRECTED] = '{
    {8'h00, 1'b1, SEC_LENGTH, 8'h00, 1'b0, NO_CAPTURE},
    {8'h00, 1'b1, SEC_LENGTH, 8'h00, 1'b0, NO_CAPTURE},
    {8'hFF, 1'b0, NO_RESULT}, {8'hFF, 1'b0, NO_RESULT}, {8'hFF, 1'b0, NO_RESULT},
    {8'hFF, 1'b0, NO_RESULT}, {8'hFF, 1'b0, NO_RESULT}, {8'hFF, 1'b0, NO_RESULT},
    {8'h12, 1'b0, NO_RESULT}, {8'h34, 1'b0, NO_RESULT}, {8'h56, 1'b0, NO_RESULT},
    {8'h78, 1'b0, NO_RESULT}, {8'h9A, 1'b0, NO_RESULT}, {8'hBC, 1'b0, NO_RESULT},
    {8'h80, 1'b0, NO_RESULT}, {8'h00, 1'b0, NO_RESULT}, {8'h00, 1'b0, NO_RESULT},
    {8'h00, 1'b0, NO_RESULT}, {8'h00, 1'b0, NO_RESULT}, {8'h00, 1'b0, NO_RESULT},
    {8'h00, 1'b0, NO_RESULT}, {8'h01, 1'b0, NO_RESULT},
    {8'h00, 1'b1, SEC_SIGLEN, 8'h00, 1'b1, 16'h0000, 48'hFFFF_FFFF_FFFF,
     48'h1234_5678_9ABC, 64'h8000_0000_0000_0001, 8'h00}
  };

  length_prefixed_packet_deframer dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_byte_value           (in_byte_value),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_byte_kind           (out_byte_kind),
    .out_byte_echo           (out_byte_echo),
    .out_last                (out_last),
    .out_payload_length      (out_payload_length),
    .out_source_address      (out_source_address),
    .out_destination_address (out_destination_address),
    .out_time_stamp          (out_time_stamp),
    .out_signature_length    (out_signature_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic reset_parser();
    p_section = SEC_LENGTH;
    p_count   = '0;
    p_length  = '0;
    p_siglen  = '0;
    p_source  = '0;
    p_dest    = '0;
    p_stamp   = '0;
  endtask

  // Advance the parser by one byte and return the tagged byte it produces
  function automatic lppd_res_t parse_byte(input logic [BYTE_W-1:0] b);
    lppd_res_t r;
    logic      done;
    r    = '0;
    done = 1'b0;
    if (p_section > SEC_SIG) begin
      p_section = SEC_LENGTH;
      p_count   = '0;
    end
    r.byte_kind = p_section;
    r.byte_echo = b;
    case (p_section)
      SEC_LENGTH: begin
        if (p_count == 0) begin
          // clear captures on the first length byte
          p_length = {b, 8'h00};
          p_source = '0;
          p_dest   = '0;
          p_stamp  = '0;
          p_siglen = '0;
          p_count  = 1;
        end else begin
          p_length[7:0] = b;
          p_section     = SEC_ADDRESS;
          p_count       = '0;
        end
      end
      SEC_ADDRESS: begin
        if (p_count < ADDRESS_BYTES_DEF)
          p_source = {p_source[ADDR_W-BYTE_W-1:0], b};
        else
          p_dest = {p_dest[ADDR_W-BYTE_W-1:0], b};
        p_count = p_count + 1'b1;
        if (p_count >= 2 * ADDRESS_BYTES_DEF) begin
          p_section = (p_length == 0) ? SEC_STAMP : SEC_PAYLOAD;
          p_count   = '0;
        end
      end
      SEC_PAYLOAD: begin
        p_count = p_count + 1'b1;
        if (p_count >= p_length) begin
          p_section = SEC_STAMP;
          p_count   = '0;
        end
      end
      SEC_STAMP: begin
        p_stamp = {p_stamp[STAMP_W-BYTE_W-1:0], b};
        p_count = p_count + 1'b1;
        if (p_count >= STAMP_BYTES) begin
          p_section = SEC_SIGLEN;
          p_count   = '0;
        end
      end
      SEC_SIGLEN: begin
        p_siglen  = b;
        done      = (b == 0);
        p_section = done ? SEC_LENGTH : SEC_SIG;
        p_count   = '0;
      end
      default: begin
        p_count = p_count + 1'b1;
        if (p_count >= p_siglen) begin
          done      = 1'b1;
          p_section = SEC_LENGTH;
          p_count   = '0;
        end
      end
    endcase
    if (done) begin
      r.last                = 1'b1;
      r.payload_length      = p_length;
      r.source_address      = p_source;
      r.destination_address = p_dest;
      r.time_stamp          = p_stamp;
      r.signature_length    = p_siglen;
    end
    return r;
  endfunction

  // Offer one byte, hold it until the transaction, then queue its expected result
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                           input lppd_res_t typed_res);
    lppd_res_t pred;
    if (!calm && ($urandom_range(0, 99) < gap_pct)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte_value <= b;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pred = parse_byte(b);
    deframed_due.push_back(typed ? typed_res : pred);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [LEN_W-1:0] plen, input logic [SIGLEN_W-1:0] slen);
    case ($urandom_range(0, 2))
      0:       gap_pct = 0;
      1:       gap_pct = 10;
      default: gap_pct = 35;
    endcase
    send_byte(plen[15:8], 1'b0, NO_RESULT);
    send_byte(plen[7:0], 1'b0, NO_RESULT);
    repeat (2 * ADDRESS_BYTES_DEF) send_byte(8'($urandom), 1'b0, NO_RESULT);
    repeat (plen) send_byte(8'($urandom), 1'b0, NO_RESULT);
    repeat (STAMP_BYTES) send_byte(8'($urandom), 1'b0, NO_RESULT);
    send_byte(slen, 1'b0, NO_RESULT);
    repeat (slen) send_byte(8'($urandom), 1'b0, NO_RESULT);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Receiver: random stall bursts, one long hold-off to back up the input
  initial begin : receiver
    int rx_cycle;
    int stall_left;
    int hold_left;
    int stall_pct;
    rx_cycle   = 0;
    stall_left = 0;
    hold_left  = 0;
    stall_pct  = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle % 200 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      if (rx_cycle == PRESSURE_AT) hold_left = PRESSURE_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Sample at the falling edge, where all signals are settled for the next rising edge
  always @(negedge clk) begin
    lppd_res_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (deframed_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected byte, expected none, got kind %0d echo %0h",
                   $time, out_byte_kind, out_byte_echo);
        end else begin
          want = deframed_due.pop_front();
          check_field("byte_kind", 64'(want.byte_kind), 64'(out_byte_kind));
          check_field("byte_echo", 64'(want.byte_echo), 64'(out_byte_echo));
          check_field("last", 64'(want.last), 64'(out_last));
          check_field("payload_length", 64'(want.payload_length), 64'(out_payload_length));
          check_field("source_address", 64'(want.source_address), 64'(out_source_address));
          check_field("destination_address", 64'(want.destination_address),
                      64'(out_destination_address));
          check_field("time_stamp", want.time_stamp, out_time_stamp);
          check_field("signature_length", 64'(want.signature_length),
                      64'(out_signature_length));
          bytes_checked++;
          if (want.last) frames_seen++;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no transaction for %0d cycles, %0d bytes still due",
                   $time, quiet_cycles, deframed_due.size());
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    logic [LEN_W-1:0]    plen;
    logic [SIGLEN_W-1:0] slen;
    int                  pick;
    reset_parser();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].res);

    while (bytes_sent < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 20)      plen = 0;
      else if (pick < 75) plen = $urandom_range(1, 12);
      else if (pick < 93) plen = $urandom_range(13, 64);
      else                plen = $urandom_range(250, 300);
      pick = $urandom_range(0, 99);
      if (pick < 25)      slen = 0;
      else if (pick < 85) slen = $urandom_range(1, 8);
      else if (pick < 97) slen = $urandom_range(9, 40);
      else                slen = 8'hFF;
      send_frame(plen, slen);
    end

    // Last stretch: longest signature with no idling on either side
    calm = 1'b1;
    send_frame(16'd40, 8'hFF);
    in_valid <= 1'b0;

    while (deframed_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d bytes in %0d frames: empty and random payloads up to 300 bytes,",
             bytes_checked, frames_seen);
    $display("empty and 255-byte signatures, random stalls and a %0d-cycle output hold-off.",
             PRESSURE_CYCLES);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
